>>> hw/rtl/dbmc_pkg.sv
`default_nettype none

package dbmc_pkg;

    typedef enum logic
    {
        MODE_LOAD   = 1'b0,
        MODE_DECODE = 1'b1
    } mode_t;

    typedef enum logic [2:0]
    {
        FMT_RAW       = 3'd0,
        FMT_RLE       = 3'd1,
        FMT_BITMASK   = 3'd2,
        FMT_ONEBIT    = 3'd3,
        FMT_TWOADJ    = 3'd4,
        FMT_FOURADJ   = 3'd5,
        FMT_TWOANY    = 3'd6,
        FMT_DIRECT    = 3'd7
    } fmt_t;

    localparam int POS_BITS  = 5;
    localparam int MASK_BITS = 4;
    localparam int OUT_BITS  = 32;

    typedef struct packed
    {
        fmt_t                   format;
        logic [POS_BITS-1:0]    first_position;
        logic [POS_BITS-1:0]    second_position;
        logic [MASK_BITS-1:0]   mask_bits;
    } rec_t;

endpackage

`default_nettype wire

>>> hw/rtl/dictionary_bitmask_code_decompressor.sv
`default_nettype none

// Channel   Handshake                    Payload
// item      item_valid / item_ready      mode format raw_word dict_index first_position
//                                        second_position mask_bits repeat_count
// result    result_valid / result_ready  out_word last_of_run no_previous
//
// Decode request: dictionary read and fields registered on accept; the expand stage
// then fills the output register, which drives result_valid. One request per cycle
// while the output is free and no run repeats. A run holds its stage for repeat_count+1
// copies, one per cycle while the output is free (one result if no previous word).
// Load requests write the dictionary at accept and produce no result.
// Dictionary contents are undefined after reset; previous word clears to zero.
// result_ready low stalls the output register and, behind it, the expand stage.

module dictionary_bitmask_code_decompressor #(
    parameter int DICT_INDEX_BITS = 4,
    parameter int WORD_BITS       = 32,
    parameter int RUN_BITS        = 3
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  item_valid,
    output logic                                       item_ready,
    input  wire logic                                  mode,
    input  wire logic [2:0]                            format,
    input  wire logic [31:0]                           raw_word,
    input  wire logic [DICT_INDEX_BITS-1:0]            dict_index,
    input  wire logic [dbmc_pkg::POS_BITS-1:0]         first_position,
    input  wire logic [dbmc_pkg::POS_BITS-1:0]         second_position,
    input  wire logic [dbmc_pkg::MASK_BITS-1:0]        mask_bits,
    input  wire logic [RUN_BITS-1:0]                   repeat_count,
    output logic                                       result_valid,
    input  wire logic                                  result_ready,
    output logic [dbmc_pkg::OUT_BITS-1:0]              out_word,
    output logic                                       last_of_run,
    output logic                                       no_previous
);

    import dbmc_pkg::*;

    logic                   accept;
    logic                   decode_in;
    logic                   load_in;
    logic [WORD_BITS-1:0]   raw_in;

    logic                   s1_valid_reg;
    logic                   s1_valid_next;
    rec_t                   s1_rec_reg;
    logic [WORD_BITS-1:0]   s1_raw_reg;
    logic [RUN_BITS-1:0]    s1_count_reg;
    logic [RUN_BITS-1:0]    run_cnt_reg;
    logic [RUN_BITS-1:0]    run_cnt_next;

    logic [WORD_BITS-1:0]   prev_word_reg;
    logic [WORD_BITS-1:0]   prev_word_next;
    logic                   prev_valid_reg;
    logic                   prev_valid_next;

    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [OUT_BITS-1:0]    out_word_reg;
    logic                   out_last_reg;
    logic                   out_nop_reg;

    logic [WORD_BITS-1:0]   entry;
    logic [WORD_BITS-1:0]   expanded;
    logic                   out_free;
    logic                   s1_issue;
    logic                   s1_done;
    logic                   is_rle;
    logic [WORD_BITS-1:0]   issue_word;
    logic                   issue_last;
    logic                   issue_nop;

    assign accept    = item_valid && item_ready;
    assign decode_in = accept && (mode_t'(mode) == MODE_DECODE);
    assign load_in   = accept && (mode_t'(mode) == MODE_LOAD);
    assign raw_in    = WORD_BITS'(raw_word);

    dbmc_dict #(
        .DICT_INDEX_BITS (DICT_INDEX_BITS),
        .WORD_BITS       (WORD_BITS)
    ) u_dict (
        .clk      (clk),
        .wr_en    (load_in),
        .wr_index (dict_index),
        .wr_data  (raw_in),
        .rd_en    (decode_in),
        .rd_index (dict_index),
        .rd_data  (entry)
    );

    dbmc_expand #(
        .WORD_BITS (WORD_BITS)
    ) u_expand (
        .rec   (s1_rec_reg),
        .entry (entry),
        .raw   (s1_raw_reg),
        .word  (expanded)
    );

    assign out_free   = !out_valid_reg || result_ready;
    assign s1_issue   = s1_valid_reg && out_free;
    assign is_rle     = (s1_rec_reg.format == FMT_RLE);
    assign s1_done    = s1_issue
                        && (!is_rle || !prev_valid_reg || (run_cnt_reg == s1_count_reg));
    assign item_ready = !s1_valid_reg || s1_done;

    always_comb
    begin
        if (!is_rle)
        begin
            issue_word = expanded;
            issue_last = 1'b1;
            issue_nop  = 1'b0;
        end
        else if (!prev_valid_reg)
        begin
            issue_word = '0;
            issue_last = 1'b1;
            issue_nop  = 1'b1;
        end
        else
        begin
            issue_word = prev_word_reg;
            issue_last = (run_cnt_reg == s1_count_reg);
            issue_nop  = 1'b0;
        end
    end

    always_comb
    begin
        s1_valid_next   = s1_valid_reg;
        run_cnt_next    = run_cnt_reg;
        prev_word_next  = prev_word_reg;
        prev_valid_next = prev_valid_reg;
        out_valid_next  = out_valid_reg;

        if (decode_in)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_done)
        begin
            s1_valid_next = 1'b0;
        end

        if (s1_done)
        begin
            run_cnt_next = '0;
        end
        else if (s1_issue)
        begin
            run_cnt_next = run_cnt_reg + RUN_BITS'(1);
        end

        if (s1_issue && !is_rle)
        begin
            prev_word_next  = expanded;
            prev_valid_next = 1'b1;
        end

        if (s1_issue)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            run_cnt_reg    <= '0;
            prev_word_reg  <= '0;
            prev_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg   <= s1_valid_next;
            run_cnt_reg    <= run_cnt_next;
            prev_word_reg  <= prev_word_next;
            prev_valid_reg <= prev_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (decode_in)
        begin
            s1_rec_reg.format          <= fmt_t'(format);
            s1_rec_reg.first_position  <= first_position;
            s1_rec_reg.second_position <= second_position;
            s1_rec_reg.mask_bits       <= mask_bits;
            s1_raw_reg                 <= raw_in;
            s1_count_reg               <= repeat_count;
        end
        if (s1_issue)
        begin
            out_word_reg <= OUT_BITS'(issue_word);
            out_last_reg <= issue_last;
            out_nop_reg  <= issue_nop;
        end
    end

    assign result_valid = out_valid_reg;
    assign out_word     = out_word_reg;
    assign last_of_run  = out_last_reg;
    assign no_previous  = out_nop_reg;

    a_nop_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && no_previous |-> last_of_run)
        else $error("no_previous result not marked last");

    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !item_ready |=> s1_valid_reg)
        else $error("expand stage dropped a request");

    a_run_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> run_cnt_reg == '0)
        else $error("run counter not cleared");

    a_nop_needs_empty: assert property (@(posedge clk) disable iff (!rst_n)
        s1_issue && issue_nop |-> !prev_valid_reg && is_rle)
        else $error("no_previous raised with a previous word");

endmodule

`default_nettype wire

>>> hw/rtl/dbmc_dict.sv
`default_nettype none

module dbmc_dict #(
    parameter int DICT_INDEX_BITS = 4,
    parameter int WORD_BITS       = 32
) (
    input  wire logic                       clk,
    input  wire logic                       wr_en,
    input  wire logic [DICT_INDEX_BITS-1:0] wr_index,
    input  wire logic [WORD_BITS-1:0]       wr_data,
    input  wire logic                       rd_en,
    input  wire logic [DICT_INDEX_BITS-1:0] rd_index,
    output logic      [WORD_BITS-1:0]       rd_data
);

    localparam int DEPTH = 1 << DICT_INDEX_BITS;

    logic [WORD_BITS-1:0] mem [DEPTH];
    logic [WORD_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_index] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_index];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> hw/rtl/dbmc_expand.sv
`default_nettype none

module dbmc_expand #(
    parameter int WORD_BITS = 32
) (
    input  wire dbmc_pkg::rec_t         rec,
    input  wire logic [WORD_BITS-1:0]   entry,
    input  wire logic [WORD_BITS-1:0]   raw,
    output logic      [WORD_BITS-1:0]   word
);

    import dbmc_pkg::*;

    // patterns left-aligned, then shifted down by the MSB-relative position
    logic [WORD_BITS-1:0] top_one;
    logic [WORD_BITS-1:0] top_two;
    logic [WORD_BITS-1:0] top_four;
    logic [WORD_BITS-1:0] top_mask;
    logic [WORD_BITS-1:0] flip_one;
    logic [WORD_BITS-1:0] flip_second;

    assign top_one  = {1'b1, {(WORD_BITS-1){1'b0}}};
    assign top_two  = {2'b11, {(WORD_BITS-2){1'b0}}};
    assign top_four = {4'b1111, {(WORD_BITS-4){1'b0}}};
    assign top_mask = {rec.mask_bits, {(WORD_BITS-MASK_BITS){1'b0}}};

    assign flip_one    = top_one >> rec.first_position;
    assign flip_second = top_one >> rec.second_position;

    always_comb
    begin
        unique case (rec.format)
            FMT_RAW:     word = raw;
            FMT_RLE:     word = entry;
            FMT_BITMASK: word = entry ^ (top_mask >> rec.first_position);
            FMT_ONEBIT:  word = entry ^ flip_one;
            FMT_TWOADJ:  word = entry ^ (top_two >> rec.first_position);
            FMT_FOURADJ: word = entry ^ (top_four >> rec.first_position);
            FMT_TWOANY:  word = entry ^ flip_one ^ flip_second;
            FMT_DIRECT:  word = entry;
        endcase
    end

endmodule

`default_nettype wire
